[sv/crc_fbe_pkg.sv]
// Shared types and constants for the forward/backward CRC engine.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package crc_fbe_pkg;

    localparam int FIELD_W = 64;
    localparam int LEN_W   = 7;

    // operation codes
    localparam logic [1:0] OP_RESTART  = 2'd0;
    localparam logic [1:0] OP_FORWARD  = 2'd1;
    localparam logic [1:0] OP_BACKWARD = 2'd2;
    localparam logic [1:0] OP_LOAD     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_POLY   = 2'd1;
    localparam logic [1:0] REG_INIT   = 2'd2;

    localparam logic [LEN_W-1:0]   LENGTH_RST = 7'd32;
    localparam logic [FIELD_W-1:0] POLY_RST   = 64'd10487813;
    localparam logic [FIELD_W-1:0] INIT_RST   = 64'd0;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         data_byte;
        logic [FIELD_W-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] crc_value;
        logic               is_zero;
        logic               is_all_ones;
        logic               backward_invalid;
    } result_t;

endpackage

[sv/crc_forward_backward_engine_top.sv]
// Top level of the forward/backward CRC engine: input register, step logic, result register.
// Depends on crc_fbe_pkg, crc_fbe_cfg and crc_fbe_step.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   item     | item_valid / item_stall   | item   (opcode, byte, load value)
//   result   | result_valid/result_stall | result (crc, flags)
//   config   | cfg_we (no wait)          | cfg_index, cfg_wdata
//
// One transfer per cycle in each direction while no stall is raised; an accepted item
// passes the input register and then the result register before result_valid rises.
// The CRC register closes its loop through the combinational step logic, setting the rate.
// Reset clears the CRC to zero and loads the configuration defaults.
// A result stall holds the result register; the input register still takes an item if
// it is empty, and item_stall rises while it holds one.
module crc_forward_backward_engine_top #(
    parameter int MAX_CRC_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  crc_fbe_pkg::item_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output crc_fbe_pkg::result_t            result,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [crc_fbe_pkg::FIELD_W-1:0] cfg_wdata
);

    localparam int N  = MAX_CRC_BITS;
    localparam int LW = $clog2(MAX_CRC_BITS + 1);

    logic                 s1_valid_reg;
    crc_fbe_pkg::item_t   s1_data_reg;
    logic                 out_valid_reg;
    crc_fbe_pkg::result_t out_data_reg;
    logic [N-1:0]         crc_reg;

    logic [N-1:0]  mask;
    logic [N-1:0]  top;
    logic [LW-1:0] shamt;
    logic [N-1:0]  poly_m;
    logic [N-1:0]  init_m;
    logic [N-1:0]  crc_next;
    logic          bad;
    logic          accept;
    logic          out_load;

    crc_fbe_cfg #(.N(N), .LW(LW)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .mask      (mask),
        .top       (top),
        .shamt     (shamt),
        .poly_m    (poly_m),
        .init_m    (init_m)
    );

    crc_fbe_step #(.N(N), .LW(LW)) u_step (
        .crc        (crc_reg),
        .opcode     (s1_data_reg.opcode),
        .data_byte  (s1_data_reg.data_byte),
        .load_value (s1_data_reg.load_value[N-1:0]),
        .mask       (mask),
        .top        (top),
        .shamt      (shamt),
        .poly_m     (poly_m),
        .init_m     (init_m),
        .crc_next   (crc_next),
        .bad        (bad)
    );

    assign out_load   = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !out_load;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= item;
        if (out_load)
        begin
            out_data_reg.crc_value        <= crc_fbe_pkg::FIELD_W'(crc_next);
            out_data_reg.is_zero          <= (crc_next == '0);
            out_data_reg.is_all_ones      <= (crc_next == mask);
            out_data_reg.backward_invalid <= bad;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

[sv/crc_fbe_cfg.sv]
// Configuration registers and the width-derived mask, top bit and alignment shift.
// Depends on crc_fbe_pkg.
module crc_fbe_cfg #(
    parameter int N  = 64,
    parameter int LW = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [crc_fbe_pkg::FIELD_W-1:0]   cfg_wdata,
    output logic [N-1:0]                      mask,
    output logic [N-1:0]                      top,
    output logic [LW-1:0]                     shamt,
    output logic [N-1:0]                      poly_m,
    output logic [N-1:0]                      init_m
);

    logic [crc_fbe_pkg::LEN_W-1:0]   len_reg;
    logic [crc_fbe_pkg::FIELD_W-1:0] poly_reg;
    logic [crc_fbe_pkg::FIELD_W-1:0] init_reg;
    logic [LW-1:0]                   width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= crc_fbe_pkg::LENGTH_RST;
            poly_reg <= crc_fbe_pkg::POLY_RST;
            init_reg <= crc_fbe_pkg::INIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crc_fbe_pkg::REG_LENGTH: len_reg  <= cfg_wdata[crc_fbe_pkg::LEN_W-1:0];
                crc_fbe_pkg::REG_POLY:   poly_reg <= cfg_wdata;
                crc_fbe_pkg::REG_INIT:   init_reg <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // width clamped to 8..N
    always_comb
    begin
        priority if (len_reg < 7'd8)
            width = LW'(8);
        else if (32'(len_reg) > N)
            width = LW'(N);
        else
            width = len_reg[LW-1:0];
    end

    assign shamt  = LW'(N) - width;
    assign mask   = {N{1'b1}} >> shamt;
    assign top    = N'(1) << (width - LW'(1));
    assign poly_m = poly_reg[N-1:0] & mask;
    assign init_m = init_reg[N-1:0] & mask;

endmodule

[sv/crc_fbe_step.sv]
// One operation on the CRC value: restart, load, forward or backward byte step.
// Depends on crc_fbe_pkg; purely combinational.
module crc_fbe_step #(
    parameter int N  = 64,
    parameter int LW = 7
) (
    input  logic [N-1:0]  crc,
    input  logic [1:0]    opcode,
    input  logic [7:0]    data_byte,
    input  logic [N-1:0]  load_value,
    input  logic [N-1:0]  mask,
    input  logic [N-1:0]  top,
    input  logic [LW-1:0] shamt,
    input  logic [N-1:0]  poly_m,
    input  logic [N-1:0]  init_m,
    output logic [N-1:0]  crc_next,
    output logic          bad
);

    logic [N-1:0] crc_m;
    logic [N-1:0] byte_hi;
    logic [N-1:0] fwd;
    logic [N-1:0] fwd_poly;
    logic [N-1:0] bwd;

    assign crc_m   = crc & mask;
    assign byte_hi = {data_byte, {(N-8){1'b0}}};

    // forward: work left-aligned so the tested bit is always the MSB
    always_comb
    begin
        fwd      = (crc_m << shamt) ^ byte_hi;
        fwd_poly = poly_m << shamt;
        for (int i = 0; i < 8; i++)
        begin
            if (fwd[N-1])
                fwd = (fwd << 1) ^ fwd_poly;
            else
                fwd = fwd << 1;
        end
    end

    // backward: undo eight shifts, odd poly guarantees a set bit 0 came from a reduction
    always_comb
    begin
        bwd = crc_m;
        for (int i = 0; i < 8; i++)
        begin
            if (bwd[0])
                bwd = ((bwd ^ poly_m) >> 1) | top;
            else
                bwd = bwd >> 1;
        end
        bwd = (bwd ^ (byte_hi >> shamt)) & mask;
    end

    always_comb
    begin
        bad = 1'b0;
        unique case (opcode)
            crc_fbe_pkg::OP_RESTART: crc_next = init_m;
            crc_fbe_pkg::OP_LOAD:    crc_next = load_value & mask;
            crc_fbe_pkg::OP_FORWARD: crc_next = fwd >> shamt;
            default:
            begin
                if (!poly_m[0])
                begin
                    bad      = 1'b1;
                    crc_next = crc_m;
                end
                else
                    crc_next = bwd;
            end
        endcase
    end

endmodule

[tb/tb_crc_forward_backward_engine_top.sv]
// Self-checking testbench for crc_forward_backward_engine_top.
// Depends on crc_fbe_pkg and the engine RTL; a built-in CRC predictor checks every result.
`timescale 1ns / 1ps

module tb_crc_forward_backward_engine_top;

    import crc_fbe_pkg::*;

    localparam int MAX_CRC_BITS = 64;
    localparam int CYCLE_LIMIT  = 200000;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item_bus     = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_bus;
    logic    cfg_we       = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [FIELD_W-1:0] cfg_wdata = '0;

    // shadow copy of the engine configuration and CRC register
    logic [LEN_W-1:0]   crc_len_cfg;
    logic [FIELD_W-1:0] poly_cfg;
    logic [FIELD_W-1:0] init_cfg;
    logic [FIELD_W-1:0] crc_state;

    item_t   pending_items[$];
    result_t crc_expect[$];
    bit      item_taken = 1'b0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    crc_forward_backward_engine_top #(
        .MAX_CRC_BITS(MAX_CRC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item_bus),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result_bus),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // One operation (restart, load, forward or backward byte step) of the MSB-first CRC; updates the shadow register.
    function automatic result_t advance_crc(item_t it);
        int unsigned w;
        int i;
        logic [FIELD_W-1:0] msk;
        logic [FIELD_W-1:0] topbit;
        logic [FIELD_W-1:0] pl;
        logic [FIELD_W-1:0] c;
        logic [FIELD_W-1:0] b;
        logic bad;
        result_t r;
        w = (crc_len_cfg < 8) ? 8 : ((crc_len_cfg > MAX_CRC_BITS) ? MAX_CRC_BITS : crc_len_cfg);
        msk = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        topbit = 64'd1 << (w - 1);
        pl = poly_cfg & msk;
        c = crc_state & msk;
        b = {56'd0, it.data_byte} << (w - 8);
        bad = 1'b0;
        case (it.opcode)
            OP_RESTART: c = init_cfg & msk;
            OP_LOAD:    c = it.load_value & msk;
            OP_FORWARD:
            begin
                c = c ^ b;
                for (i = 0; i < 8; i++)
                begin
                    if ((c & topbit) != 0)
                        c = ((c << 1) ^ pl) & msk;
                    else
                        c = (c << 1) & msk;
                end
            end
            default:
            begin
                // backward step needs an odd polynomial; otherwise hold the register
                if (pl[0] == 1'b0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (i = 0; i < 8; i++)
                    begin
                        if (c[0])
                            c = ((c ^ pl) >> 1) | topbit;
                        else
                            c = c >> 1;
                    end
                    c = (c ^ b) & msk;
                end
            end
        endcase
        crc_state = c;
        r.crc_value = c;
        r.is_zero = (c == 0);
        r.is_all_ones = (c == msk);
        r.backward_invalid = bad;
        return r;
    endfunction

    function automatic item_t mk_item(logic [1:0] op, logic [7:0] b, logic [FIELD_W-1:0] v);
        item_t it;
        it.opcode = op;
        it.data_byte = b;
        it.load_value = v;
        return it;
    endfunction

    function automatic void add_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver: a new item only once the previous transfer completed
    always @(negedge clk)
    begin
        if (!item_valid || item_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item_bus <= pending_items[0];
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // accepted items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            crc_expect.insert(crc_expect.size(), advance_crc(item_bus));
            void'(pending_items.pop_front());
            item_taken = 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (crc_expect.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, result_bus);
                error_count++;
            end
            else
            begin
                exp_r = crc_expect.pop_front();
                if (result_bus.crc_value !== exp_r.crc_value)
                begin
                    $display("%0t crc_value: expected %h, actual %h",
                             $time, exp_r.crc_value, result_bus.crc_value);
                    error_count++;
                end
                if (result_bus.is_zero !== exp_r.is_zero)
                begin
                    $display("%0t is_zero: expected %b, actual %b",
                             $time, exp_r.is_zero, result_bus.is_zero);
                    error_count++;
                end
                if (result_bus.is_all_ones !== exp_r.is_all_ones)
                begin
                    $display("%0t is_all_ones: expected %b, actual %b",
                             $time, exp_r.is_all_ones, result_bus.is_all_ones);
                    error_count++;
                end
                if (result_bus.backward_invalid !== exp_r.backward_invalid)
                begin
                    $display("%0t backward_invalid: expected %b, actual %b",
                             $time, exp_r.backward_invalid, result_bus.backward_invalid);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_crc_forward_backward_engine_top failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [FIELD_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LENGTH: crc_len_cfg = val[LEN_W-1:0];
            REG_POLY:   poly_cfg = val;
            default:    init_cfg = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every transfer to drain
    task automatic drain();
        while (pending_items.size() != 0 || crc_expect.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 61;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 61;
            end
            default:
            begin
                send_idle_pct = 33;
                stall_pct = 33;
            end
        endcase
    endtask

    // Mostly restart/load followed by a forward run, usually with its backward undo;
    // the rest is random noise.
    task automatic queue_random(int n);
        logic [7:0] run_bytes[8];
        int cnt;
        int k;
        int j;
        logic [FIELD_W-1:0] v;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    add_item(mk_item(OP_RESTART, 8'($urandom), rand64()));
                end
                else
                begin
                    v = ($urandom_range(0, 3) == 0) ? '1 : rand64();
                    add_item(mk_item(OP_LOAD, 8'($urandom), v));
                end
                k = $urandom_range(1, 8);
                for (j = 0; j < k; j++)
                begin
                    run_bytes[j] = 8'($urandom);
                    add_item(mk_item(OP_FORWARD, run_bytes[j], rand64()));
                end
                cnt += k + 1;
                if ($urandom_range(0, 2) != 0)
                begin
                    for (j = k - 1; j >= 0; j--)
                        add_item(mk_item(OP_BACKWARD, run_bytes[j], rand64()));
                    cnt += k;
                end
            end
            else
            begin
                add_item(mk_item(2'($urandom_range(0, 3)), 8'($urandom), rand64()));
                cnt++;
            end
        end
    endtask

    initial
    begin
        int p;
        logic [FIELD_W-1:0] pl;
        crc_len_cfg = LENGTH_RST;
        poly_cfg = POLY_RST;
        init_cfg = INIT_RST;
        crc_state = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: 32-bit CRC, odd polynomial
        set_idle(0);
        add_item(mk_item(OP_FORWARD, 8'h00, '1));
        add_item(mk_item(OP_RESTART, 8'hFF, '1));
        add_item(mk_item(OP_FORWARD, 8'hFF, '0));
        add_item(mk_item(OP_BACKWARD, 8'hFF, '1));
        add_item(mk_item(OP_LOAD, 8'hFF, '1));
        add_item(mk_item(OP_FORWARD, 8'h5A, '0));
        add_item(mk_item(OP_BACKWARD, 8'h5A, '0));
        add_item(mk_item(OP_LOAD, 8'h00, '0));
        drain();

        write_reg(REG_LENGTH, 64'd64);
        write_reg(REG_POLY, 64'h42F0E1EBA9EA3693);
        write_reg(REG_INIT, '1);
        add_item(mk_item(OP_RESTART, 8'h00, '0));
        add_item(mk_item(OP_FORWARD, 8'hA5, '0));
        add_item(mk_item(OP_FORWARD, 8'h3C, '0));
        add_item(mk_item(OP_BACKWARD, 8'h3C, '0));
        add_item(mk_item(OP_BACKWARD, 8'hA5, '0));
        add_item(mk_item(OP_LOAD, 8'hFF, 64'h0123456789ABCDEF));
        drain();

        // narrowing the width without a restart masks the held register
        write_reg(REG_LENGTH, 64'd8);
        add_item(mk_item(OP_FORWARD, 8'h80, '0));
        add_item(mk_item(OP_BACKWARD, 8'h80, '0));
        add_item(mk_item(OP_LOAD, 8'h00, '1));
        drain();

        // width below range acts as 8; even polynomial blocks the backward step
        write_reg(REG_LENGTH, 64'd0);
        write_reg(REG_POLY, 64'h04C11DB6);
        add_item(mk_item(OP_FORWARD, 8'hFF, '0));
        add_item(mk_item(OP_BACKWARD, 8'h12, '0));
        add_item(mk_item(OP_RESTART, 8'h00, '0));
        drain();

        // width above range acts as 64
        write_reg(REG_LENGTH, 64'd127);
        write_reg(REG_INIT, '0);
        add_item(mk_item(OP_RESTART, 8'h00, '1));
        add_item(mk_item(OP_BACKWARD, 8'h55, '0));
        add_item(mk_item(OP_FORWARD, 8'h01, '0));
        drain();

        for (p = 0; p < 8; p++)
        begin
            set_idle(p % 4);
            case (p)
                0:       write_reg(REG_LENGTH, 64'd8);
                1:       write_reg(REG_LENGTH, 64'd64);
                2:       write_reg(REG_LENGTH, 64'($urandom_range(0, 7)));
                3:       write_reg(REG_LENGTH, 64'($urandom_range(65, 127)));
                4:       write_reg(REG_LENGTH, 64'd32);
                default: write_reg(REG_LENGTH, 64'($urandom_range(8, 64)));
            endcase
            pl = rand64();
            if ($urandom_range(0, 3) != 0)
                pl[0] = 1'b1;
            write_reg(REG_POLY, pl);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_INIT, '0);
                1:       write_reg(REG_INIT, '1);
                default: write_reg(REG_INIT, rand64());
            endcase
            queue_random(50);
            drain();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0 && crc_expect.size() == 0)
            $display("tb_crc_forward_backward_engine_top passed");
        else
            $display("tb_crc_forward_backward_engine_top failed");
        $finish;
    end

endmodule
